>>> rtl/trial_division_factorizer_defines.svh
// assertion helpers for the checker file
`ifndef TRIAL_DIVISION_FACTORIZER_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_DEFINES_SVH

// property checked every clock, off while reset is held
`define TDF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define TDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tdf_pkg.sv
package tdf_pkg;

  // most factors reported for one input
  localparam int MaxResults = 48;
  localparam int CNT_W      = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NONE,
    ST_START,
    ST_DIV,
    ST_EVAL,
    ST_FINISH,
    ST_FLUSH
  } state_e;

  // which divisor family is being tried
  typedef enum logic [2:0] {
    PH_TWO,
    PH_THREE,
    PH_CHK,
    PH_A,
    PH_B
  } phase_e;

  typedef enum logic [2:0] {
    X_HOLD,
    X_TWO,
    X_THREE,
    X_FIVE,
    X_ADD2,
    X_ADD4
  } x_op_e;

  typedef struct packed {
    logic  load;
    logic  div_start;
    x_op_e x_op;
    logic  push_div;
    logic  push_rem;
    logic  flush;
    logic  emit_none;
  } tdf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic r_zero;
    logic q_lt_x;
    logic rem_gt1;
    logic pend_v;
    logic cap_next;
    logic out_free;
    logic value_le1;
  } tdf_status_t;

endpackage

>>> rtl/tdf_in_if.sv
interface tdf_in_if #(
  parameter int WIDTH = 48
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> rtl/tdf_out_if.sv
interface tdf_out_if #(
  parameter int WIDTH = 48
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] factor;
  logic             last;
  logic             none;

  modport source (output valid, output factor, output last, output none, input ready);
  modport sink (input valid, input factor, input last, input none, output ready);
endinterface

>>> rtl/tdf_div.sv
module tdf_div #(
  parameter int WIDTH = 48,
  parameter int DW    = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [DW-1:0]    rem_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [DW-1:0]    part_q, part_d;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             take;

  // one quotient bit per cycle, restoring
  assign trial = {part_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign take  = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    part_d = part_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH);
      quo_d  = dividend_i;
      part_d = '0;
    end else if (busy_q) begin
      quo_d  = {quo_q[WIDTH-2:0], take};
      part_d = take ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    part_q <= part_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = part_q;

endmodule

>>> rtl/tdf_datapath.sv
module tdf_datapath #(
  parameter int WIDTH = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdf_pkg::tdf_cmd_t    cmd_i,
  output tdf_pkg::tdf_status_t status_o,
  input  logic [WIDTH-1:0]     in_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WIDTH-1:0]     out_factor_o,
  output logic                 out_last_o,
  output logic                 out_none_o
);
  import tdf_pkg::*;

  // divisor width: covers sqrt of the value plus the wheel step
  localparam int DW = (WIDTH + 1) / 2 + 2;

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [DW-1:0]    x_q, x_d;
  logic [WIDTH-1:0] pend_q, pend_d;
  logic             pend_v_q, pend_v_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_factor_q, out_factor_d;
  logic             out_last_q, out_last_d;
  logic             out_none_q, out_none_d;

  logic             div_done;
  logic [WIDTH-1:0] div_quot;
  logic [DW-1:0]    div_rem;
  logic             push;
  logic             out_wr;
  logic             out_free;
  logic [WIDTH-1:0] x_wide;
  logic [WIDTH-1:0] new_factor;

  tdf_div #(
    .WIDTH (WIDTH),
    .DW    (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rem_q),
    .divisor_i  (x_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign x_wide     = {{(WIDTH - DW){1'b0}}, x_q};
  assign push       = cmd_i.push_div | cmd_i.push_rem;
  assign new_factor = cmd_i.push_rem ? rem_q : x_wide;
  assign out_free   = !out_valid_q || out_ready_i;
  // a push with a factor already held sends the held one out
  assign out_wr     = (push && pend_v_q) || cmd_i.flush || cmd_i.emit_none;

  always_comb begin
    x_d = x_q;
    unique case (cmd_i.x_op)
      X_HOLD:  x_d = x_q;
      X_TWO:   x_d = DW'(2);
      X_THREE: x_d = DW'(3);
      X_FIVE:  x_d = DW'(5);
      X_ADD2:  x_d = x_q + DW'(2);
      X_ADD4:  x_d = x_q + DW'(4);
      default: x_d = x_q;
    endcase
  end

  always_comb begin
    rem_d    = rem_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    cnt_d    = cnt_q;
    if (cmd_i.load) begin
      rem_d    = in_value_i;
      pend_v_d = 1'b0;
      cnt_d    = '0;
    end else begin
      if (cmd_i.push_div) begin
        rem_d = div_quot;
      end
      if (push) begin
        pend_d   = new_factor;
        pend_v_d = 1'b1;
        cnt_d    = cnt_q + CNT_W'(1);
      end else if (cmd_i.flush) begin
        pend_v_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_factor_d = out_factor_q;
    out_last_d   = out_last_q;
    out_none_d   = out_none_q;
    if (out_wr) begin
      out_valid_d = 1'b1;
      if (cmd_i.emit_none) begin
        out_factor_d = '0;
        out_last_d   = 1'b1;
        out_none_d   = 1'b1;
      end else begin
        out_factor_d = pend_q;
        out_last_d   = cmd_i.flush;
        out_none_d   = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_v_q    <= pend_v_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    x_q          <= x_d;
    pend_q       <= pend_d;
    out_factor_q <= out_factor_d;
    out_last_q   <= out_last_d;
    out_none_q   <= out_none_d;
  end

  assign status_o.div_done  = div_done;
  assign status_o.r_zero    = (div_rem == '0);
  assign status_o.q_lt_x    = (div_quot < x_wide);
  assign status_o.rem_gt1   = (rem_q[WIDTH-1:1] != '0);
  assign status_o.pend_v    = pend_v_q;
  assign status_o.cap_next  = (cnt_q == CNT_W'(MaxResults - 1));
  assign status_o.out_free  = out_free;
  assign status_o.value_le1 = (in_value_i[WIDTH-1:1] == '0);

  assign out_valid_o  = out_valid_q;
  assign out_factor_o = out_factor_q;
  assign out_last_o   = out_last_q;
  assign out_none_o   = out_none_q;

endmodule

>>> rtl/tdf_ctrl.sv
module tdf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tdf_pkg::tdf_status_t status_i,
  output tdf_pkg::tdf_cmd_t    cmd_o
);
  import tdf_pkg::*;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  logic   fin;
  logic   hit;
  logic   can_push;
  x_op_e  miss_x;
  phase_e miss_ph;
  phase_e hit_ph;

  // decision on the finished division
  always_comb begin
    miss_x  = X_HOLD;
    miss_ph = ph_q;
    unique case (ph_q)
      PH_TWO: begin
        miss_x  = X_THREE;
        miss_ph = PH_THREE;
      end
      PH_THREE: begin
        miss_x  = X_FIVE;
        miss_ph = PH_CHK;
      end
      PH_CHK, PH_A: begin
        miss_x  = X_ADD2;
        miss_ph = PH_B;
      end
      PH_B: begin
        miss_x  = X_ADD4;
        miss_ph = PH_CHK;
      end
      default: begin
        miss_x  = X_HOLD;
        miss_ph = ph_q;
      end
    endcase
  end

  assign fin      = (ph_q == PH_CHK) && status_i.q_lt_x;
  assign hit      = !fin && status_i.r_zero;
  assign hit_ph   = (ph_q == PH_CHK) ? PH_A : ph_q;
  assign can_push = !status_i.pend_v || status_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.value_le1 ? ST_NONE : ST_START;
          ph_d    = PH_TWO;
        end
      end
      ST_NONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (fin) begin
          state_d = ST_FINISH;
        end else if (hit) begin
          if (can_push) begin
            state_d = status_i.cap_next ? ST_FLUSH : ST_START;
            ph_d    = hit_ph;
          end
        end else begin
          state_d = ST_START;
          ph_d    = miss_ph;
        end
      end
      ST_FINISH: begin
        if (!status_i.rem_gt1 || can_push) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.x_op = X_HOLD;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.x_op = X_TWO;
        end
      end
      ST_NONE: cmd_o.emit_none = status_i.out_free;
      ST_START: cmd_o.div_start = 1'b1;
      ST_DIV: ;
      ST_EVAL: begin
        if (hit) begin
          cmd_o.push_div = can_push;
        end else if (!fin) begin
          cmd_o.x_op = miss_x;
        end
      end
      ST_FINISH: cmd_o.push_rem = status_i.rem_gt1 && can_push;
      ST_FLUSH: cmd_o.flush = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_TWO;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

endmodule

>>> rtl/trial_division_factorizer.sv
// prime factorizer by trial division over the 6k-1 / 6k+1 wheel
// in_i: one beat carries the value to factor; taken only while the block is idle
// out_o: one beat per prime factor, ascending, repeats included; last marks the
//   final beat of a value; a value of 0 or 1 gives a single beat with none and
//   last set and factor 0; at most 48 beats per value, the 48th marked last
// every trial division runs through a shared restoring divider, one quotient
//   bit per cycle
// trials per value: about exponents + 3 + d_end/3, d_end being the larger of
//   the largest-but-one factor and the square root of the largest
// the next value is taken once the last beat of the previous one sits in the
//   output register
// a factor found is held one step back until the next one (or the end) shows
//   whether it is the last; a stalled receiver holds the output register and
//   the search waits only when a new factor needs that register
// reset clears the controller, the divider and the output valid; the block
//   comes up idle and ready
module trial_division_factorizer #(
  parameter int WIDTH = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdf_in_if.sink    in_i,
  tdf_out_if.source out_o
);
  import tdf_pkg::*;

  tdf_cmd_t    cmd;
  tdf_status_t status;

  // sequencer: walks divisor 2, then 3, then the wheel
  tdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // value, divisor, held factor, divider and output register
  tdf_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_value_i   (in_i.value),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_factor_o (out_o.factor),
    .out_last_o   (out_o.last),
    .out_none_o   (out_o.none)
  );

endmodule

>>> rtl/tdf_checker.sv
`include "trial_division_factorizer_defines.svh"

module tdf_checker #(
  parameter int WIDTH = 48
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [WIDTH-1:0] out_factor_i,
  input logic             out_last_i,
  input logic             out_none_i
);

  // stalled beat keeps its contents
  `TDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_factor_i) && $stable(out_last_i) && $stable(out_none_i), "stalled output beat changed")

  // empty result is a single closing beat with factor zero
  `TDF_ASSERT(a_none_form, clk_i, rst_ni, out_valid_i && out_none_i |-> out_last_i && (out_factor_i == '0), "none beat malformed")

  // every real factor is at least two
  `TDF_ASSERT(a_factor_min, clk_i, rst_ni, out_valid_i && !out_none_i |-> (out_factor_i > WIDTH'(1)), "factor below two")

  // one value at a time: no second accept right after one
  `TDF_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input ready right after accept")

endmodule

bind trial_division_factorizer tdf_checker #(
  .WIDTH (WIDTH)
) u_tdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_factor_i (out_o.factor),
  .out_last_i   (out_o.last),
  .out_none_i   (out_o.none)
);
